FILE: hdl/prb_pkg.sv
// Shared types and constants for the press ramp block.
package prb_pkg;

    // Value format: signed fixed point, this many bits in all.
    localparam int VALUE_WIDTH = 24;
    localparam int RATE_WIDTH  = VALUE_WIDTH - 1;
    localparam int TIMER_WIDTH = 16;
    localparam int STEP_WIDTH  = 10;
    localparam int OP_WIDTH    = 3;

    // The factor 0.01 is taken as CENT_NUM / 2^CENT_SHIFT.
    localparam int CENT_NUM   = 655;
    localparam int CENT_SHIFT = 16;
    // Width of step_time * CENT_NUM.
    localparam int K_WIDTH    = 20;

    // Operation codes.
    localparam logic [OP_WIDTH-1:0] OP_TICK       = 3'd0;
    localparam logic [OP_WIDTH-1:0] OP_PRESS_UP   = 3'd1;
    localparam logic [OP_WIDTH-1:0] OP_PRESS_DOWN = 3'd2;
    localparam logic [OP_WIDTH-1:0] OP_REL_UP     = 3'd3;
    localparam logic [OP_WIDTH-1:0] OP_REL_DOWN   = 3'd4;

    // Configuration register indexes.
    localparam int CFG_ADDR_WIDTH = 3;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_NORMAL_VALUE = 3'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_UPPER_LIMIT  = 3'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_LOWER_LIMIT  = 3'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_HOLD_DELAY   = 3'd3;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_START_STEP   = 3'd4;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_MIN_RATE     = 3'd5;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_MAX_RATE     = 3'd6;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_RECOVER_MODE = 3'd7;

    // Register reset values.
    localparam logic signed [VALUE_WIDTH-1:0] RST_NORMAL_VALUE = 24'sd0;
    localparam logic signed [VALUE_WIDTH-1:0] RST_UPPER_LIMIT  = 24'sd25600;
    localparam logic signed [VALUE_WIDTH-1:0] RST_LOWER_LIMIT  = -24'sd25600;
    localparam logic [TIMER_WIDTH-1:0]        RST_HOLD_DELAY   = 16'd0;
    localparam logic [RATE_WIDTH-1:0]         RST_START_STEP   = 23'd256;
    localparam logic [RATE_WIDTH-1:0]         RST_MIN_RATE     = 23'd0;
    localparam logic [RATE_WIDTH-1:0]         RST_MAX_RATE     = 23'd2560;

    typedef struct packed {
        logic [OP_WIDTH-1:0]   op;
        logic [STEP_WIDTH-1:0] step_time;
    } in_item_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] current_value;
        logic                          is_recovered;
    } out_item_t;

    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] normal_value;
        logic signed [VALUE_WIDTH-1:0] upper_limit;
        logic signed [VALUE_WIDTH-1:0] lower_limit;
        logic [TIMER_WIDTH-1:0]        hold_delay;
        logic [RATE_WIDTH-1:0]         start_step;
        logic [RATE_WIDTH-1:0]         min_rate;
        logic [RATE_WIDTH-1:0]         max_rate;
        logic                          recover_mode;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic calc_k;
        logic calc_mul;
        logic commit;
    } ctrl_cmd_t;

endpackage

FILE: hdl/prb_cfg.sv
// Configuration register bank of the press ramp block.
module prb_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [prb_pkg::CFG_ADDR_WIDTH-1:0]   cfg_addr,
    input  logic [prb_pkg::VALUE_WIDTH-1:0]      cfg_wdata,
    output prb_pkg::cfg_t                        cfg
);
    import prb_pkg::*;

    cfg_t cfg_reg;

    // Register writes, one index at a time.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.normal_value <= RST_NORMAL_VALUE;
            cfg_reg.upper_limit  <= RST_UPPER_LIMIT;
            cfg_reg.lower_limit  <= RST_LOWER_LIMIT;
            cfg_reg.hold_delay   <= RST_HOLD_DELAY;
            cfg_reg.start_step   <= RST_START_STEP;
            cfg_reg.min_rate     <= RST_MIN_RATE;
            cfg_reg.max_rate     <= RST_MAX_RATE;
            cfg_reg.recover_mode <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_NORMAL_VALUE: cfg_reg.normal_value <= $signed(cfg_wdata);
                CFG_UPPER_LIMIT:  cfg_reg.upper_limit  <= $signed(cfg_wdata);
                CFG_LOWER_LIMIT:  cfg_reg.lower_limit  <= $signed(cfg_wdata);
                CFG_HOLD_DELAY:   cfg_reg.hold_delay   <= cfg_wdata[TIMER_WIDTH-1:0];
                CFG_START_STEP:   cfg_reg.start_step   <= cfg_wdata[RATE_WIDTH-1:0];
                CFG_MIN_RATE:     cfg_reg.min_rate     <= cfg_wdata[RATE_WIDTH-1:0];
                CFG_MAX_RATE:     cfg_reg.max_rate     <= cfg_wdata[RATE_WIDTH-1:0];
                CFG_RECOVER_MODE: cfg_reg.recover_mode <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/prb_ctrl.sv
// Controller state machine of the press ramp block.
module prb_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output prb_pkg::ctrl_cmd_t  cmd
);
    import prb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC_K,
        ST_CALC_MUL,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   slot_free;

    // The result register can take a new result when empty or being drained.
    assign slot_free = !out_valid_reg || out_ready;

    assign in_ready     = (state_reg == ST_IDLE);
    assign cmd.load     = in_valid && in_ready;
    assign cmd.calc_k   = (state_reg == ST_CALC_K);
    assign cmd.calc_mul = (state_reg == ST_CALC_MUL);
    assign cmd.commit   = (state_reg == ST_COMMIT) && slot_free;
    assign out_valid    = out_valid_reg;

    // Sequencing of one item and the result valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.load)
                    begin
                        state_reg <= ST_CALC_K;
                    end
                end
                ST_CALC_K:   state_reg <= ST_CALC_MUL;
                ST_CALC_MUL: state_reg <= ST_COMMIT;
                ST_COMMIT:
                begin
                    if (slot_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:     state_reg <= ST_IDLE;
            endcase

            if (cmd.commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // An accepted item runs through both arithmetic stages in order.
    a_stage_order: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.calc_k ##1 cmd.calc_mul)
        else $error("item did not pass through the arithmetic stages in order");

    // No new item is taken while one is in flight.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // A committed result shows up as valid on the next cycle.
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid)
        else $error("committed result not presented");

    // At most one command is active in any cycle.
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.calc_k, cmd.calc_mul, cmd.commit}))
        else $error("more than one datapath command active");

endmodule

FILE: hdl/prb_dp.sv
// Datapath of the press ramp block: state registers, arithmetic and result register.
module prb_dp #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  prb_pkg::ctrl_cmd_t  cmd,
    input  prb_pkg::in_item_t   in_data,
    input  prb_pkg::cfg_t       cfg,
    output prb_pkg::out_item_t  out_data
);
    import prb_pkg::*;

    localparam int VW   = VALUE_WIDTH;
    localparam int RW   = RATE_WIDTH;
    localparam int DW   = VW + 1;
    localparam int PW   = DW + K_WIDTH + 1;
    localparam int QW   = PW - CENT_SHIFT;
    localparam int SW   = QW + 1;
    localparam int INCW = K_WIDTH + FRACTION_BITS - CENT_SHIFT;
    localparam int RSW  = ((RW > INCW) ? RW : INCW) + 1;
    localparam int TW   = TIMER_WIDTH + 1;

    localparam logic signed [DW-1:0] SNAP_POS = DW'(2 ** FRACTION_BITS);
    localparam logic signed [DW-1:0] SNAP_NEG = -SNAP_POS;
    localparam logic signed [SW-1:0] SAT_MAX  = SW'(2 ** (VW - 1) - 1);
    localparam logic signed [SW-1:0] SAT_MIN  = -SAT_MAX - SW'(1);

    // Item in work and pipeline registers (no reset needed).
    logic [OP_WIDTH-1:0]       op_reg;
    logic [STEP_WIDTH-1:0]     st_reg;
    logic [K_WIDTH-1:0]        k_reg;
    logic signed [DW-1:0]      diff_reg;
    logic signed [PW-1:0]      prod_reg;
    out_item_t                 out_reg;

    // Block state.
    logic signed [VW-1:0]      value_reg, value_next;
    logic [RW-1:0]             rate_reg, rate_next;
    logic [TIMER_WIDTH-1:0]    timer_reg, timer_next;
    logic                      up_reg, up_next;
    logic                      down_reg, down_next;
    logic                      rec_reg, rec_next;

    // Combinational terms.
    logic signed [VW-1:0]      hi_lim, lo_lim;
    logic [K_WIDTH+FRACTION_BITS-1:0] k_shift;
    logic [INCW-1:0]           inc;
    logic signed [DW-1:0]      start_up, start_dn;
    logic [RSW-1:0]            rate_sum;
    logic [RW-1:0]             rate_grown, rate_gap;
    logic signed [DW-1:0]      ramp_up, ramp_dn;
    logic [TW-1:0]             timer_sum;
    logic signed [SW-1:0]      rec_sum;
    logic signed [VW-1:0]      rec_value;
    logic                      near_normal;

    // Stage registers: capture, step_time * 655 and distance to normal, product, result.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_data.op;
            st_reg <= in_data.step_time;
        end
        if (cmd.calc_k)
        begin
            k_reg    <= K_WIDTH'(st_reg) * K_WIDTH'(CENT_NUM);
            diff_reg <= DW'(cfg.normal_value) - DW'(value_reg);
        end
        if (cmd.calc_mul)
        begin
            prod_reg <= PW'(diff_reg) * PW'($signed({1'b0, k_reg}));
        end
        if (cmd.commit)
        begin
            out_reg.current_value <= value_next;
            out_reg.is_recovered  <= rec_next;
        end
    end

    // Clamp limits: the larger is the upper one.
    assign hi_lim = (cfg.upper_limit > cfg.lower_limit) ? cfg.upper_limit : cfg.lower_limit;
    assign lo_lim = (cfg.upper_limit > cfg.lower_limit) ? cfg.lower_limit : cfg.upper_limit;

    // Rate change per tick: floor(step_time * 655 * 2^FRACTION_BITS / 65536).
    assign k_shift = {k_reg, {FRACTION_BITS{1'b0}}};
    assign inc     = k_shift[K_WIDTH+FRACTION_BITS-1:CENT_SHIFT];

    // Fresh press steps.
    assign start_up = DW'(value_reg) + DW'($signed({1'b0, cfg.start_step}));
    assign start_dn = DW'(value_reg) - DW'($signed({1'b0, cfg.start_step}));

    // Rate growth while held, and the ramp step it gives.
    assign rate_sum   = RSW'(rate_reg) + RSW'(inc);
    assign rate_grown = (rate_reg < cfg.max_rate)
                      ? ((rate_sum > RSW'(cfg.max_rate)) ? cfg.max_rate : RW'(rate_sum))
                      : rate_reg;
    assign ramp_up = DW'(value_reg) + DW'($signed({1'b0, rate_grown}));
    assign ramp_dn = DW'(value_reg) - DW'($signed({1'b0, rate_grown}));

    // Hold timer accumulation.
    assign timer_sum = TW'(timer_reg) + TW'(st_reg);

    // Decay headroom above the minimum rate.
    assign rate_gap = rate_reg - cfg.min_rate;

    // Slow recovery: floor of the product over 65536, then saturate.
    assign near_normal = (diff_reg < SNAP_POS) && (diff_reg > SNAP_NEG);
    assign rec_sum     = SW'(value_reg) + SW'($signed(prod_reg[PW-1:CENT_SHIFT]));
    always_comb
    begin
        if (rec_sum > SAT_MAX)
        begin
            rec_value = VW'(SAT_MAX);
        end
        else if (rec_sum < SAT_MIN)
        begin
            rec_value = VW'(SAT_MIN);
        end
        else
        begin
            rec_value = VW'(rec_sum);
        end
    end

    // Next state for the item in work.
    always_comb
    begin
        value_next = value_reg;
        rate_next  = rate_reg;
        timer_next = timer_reg;
        up_next    = up_reg;
        down_next  = down_reg;
        rec_next   = rec_reg;
        case (op_reg)
            OP_PRESS_UP:
            begin
                if (!up_reg && !down_reg)
                begin
                    timer_next = '0;
                    if (value_reg < hi_lim)
                    begin
                        value_next = (start_up > DW'(hi_lim)) ? hi_lim : VW'(start_up);
                        rec_next   = 1'b0;
                    end
                end
                up_next = 1'b1;
            end
            OP_PRESS_DOWN:
            begin
                if (!up_reg && !down_reg)
                begin
                    timer_next = '0;
                    if (value_reg > lo_lim)
                    begin
                        value_next = (start_dn < DW'(lo_lim)) ? lo_lim : VW'(start_dn);
                        rec_next   = 1'b0;
                    end
                end
                down_next = 1'b1;
            end
            OP_REL_UP:   up_next = 1'b0;
            OP_REL_DOWN: down_next = 1'b0;
            OP_TICK:
            begin
                if (up_reg != down_reg)
                begin
                    // One button held: fill the hold timer, then ramp.
                    if (timer_reg < cfg.hold_delay)
                    begin
                        timer_next = (timer_sum > TW'(cfg.hold_delay))
                                   ? cfg.hold_delay : TIMER_WIDTH'(timer_sum);
                    end
                    else
                    begin
                        rate_next = rate_grown;
                        if (up_reg)
                        begin
                            if (value_reg < hi_lim)
                            begin
                                value_next = (ramp_up > DW'(hi_lim)) ? hi_lim : VW'(ramp_up);
                                rec_next   = 1'b0;
                            end
                        end
                        else if (value_reg > lo_lim)
                        begin
                            value_next = (ramp_dn < DW'(lo_lim)) ? lo_lim : VW'(ramp_dn);
                            rec_next   = 1'b0;
                        end
                    end
                end
                else if (!up_reg)
                begin
                    // Nothing held: decay the rate and recover the value.
                    if (rate_reg > cfg.min_rate)
                    begin
                        if (RSW'(rate_gap) <= RSW'(inc))
                        begin
                            rate_next = cfg.min_rate;
                        end
                        else
                        begin
                            rate_next = rate_reg - RW'(inc);
                        end
                    end
                    if (!rec_reg)
                    begin
                        if (cfg.recover_mode || near_normal)
                        begin
                            value_next = cfg.normal_value;
                            rec_next   = 1'b1;
                        end
                        else
                        begin
                            value_next = rec_value;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // State update at commit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= RST_NORMAL_VALUE;
            rate_reg  <= RST_MIN_RATE;
            timer_reg <= '0;
            up_reg    <= 1'b0;
            down_reg  <= 1'b0;
            rec_reg   <= 1'b1;
        end
        else if (cmd.commit)
        begin
            value_reg <= value_next;
            rate_reg  <= rate_next;
            timer_reg <= timer_next;
            up_reg    <= up_next;
            down_reg  <= down_next;
            rec_reg   <= rec_next;
        end
    end

    assign out_data = out_reg;

endmodule

FILE: hdl/press_ramp_bidirectional.sv
// Top level of the press ramp block: register bank, controller and datapath.
//
// Each input item (a tick or a button event) yields exactly one result, the
// ramped value and its recovered flag after the item. An item passes through
// the accepting state, a state for step_time * 655 and the distance to the
// rest value, one for the recovery product, and one to commit the new state
// into the result register. The commit waits while an earlier result still
// sits untaken in that register, and no new item is accepted until the last
// one has committed. The user must write registers through the write port
// only while no item is in flight; the block itself does not enforce this.
module press_ramp_bidirectional #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  prb_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output prb_pkg::out_item_t                   out_data,
    input  logic                                 cfg_we,
    input  logic [prb_pkg::CFG_ADDR_WIDTH-1:0]   cfg_addr,
    input  logic [prb_pkg::VALUE_WIDTH-1:0]      cfg_wdata
);
    import prb_pkg::*;

    cfg_t      cfg;
    ctrl_cmd_t cmd;

    prb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    prb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    prb_dp #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg       (cfg),
        .out_data  (out_data)
    );

endmodule
